// ===== src/hce_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the heating cycle efficiency estimator.
// Used by the serial multiplier, the serial divider, the top level and the checker.
package hce_pkg;

  // Field widths.
  localparam int TEMP_W    = 12;
  localparam int EN_W      = 24;
  localparam int CAP_W     = 16;
  localparam int SEC_W     = 16;
  localparam int COP_W     = 16;
  localparam int EV_W      = 2;
  localparam int CFG_IDX_W = 2;

  // Arithmetic widths: tank sum in 1/64 K, its deltas, and the COP products.
  localparam int S_W       = TEMP_W + 3;
  localparam int DIFF_W    = S_W + 1;
  localparam int DELTA_W   = 14;
  localparam int MCAND_W   = CAP_W + 5;
  localparam int PROD_W    = MCAND_W + DELTA_W;
  localparam int NUM_W     = PROD_W + 1;
  localparam int DEN_W     = EN_W + 1;
  localparam int MUL_CNT_W = $clog2(DELTA_W + 1);
  localparam int DIV_CNT_W = $clog2(COP_W + 1);

  // Register reset values.
  localparam logic [CAP_W-1:0] CAP_RESET    = 16'd3722;
  localparam logic [SEC_W-1:0] WINDOW_RESET = 16'd300;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CAP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd1;

  // Result event codes.
  typedef enum logic [EV_W-1:0] {
    EV_NONE  = 2'd0,
    EV_START = 2'd1,
    EV_DONE  = 2'd2
  } ev_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } st_t;

endpackage

// ===== src/hce_mul_serial.sv =====
`timescale 1ns / 1ps
// Bit-serial shift-add multiplier: one multiplier bit per cycle, LSB first.
// Depends on hce_pkg for the operand widths.
module hce_mul_serial import hce_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [MCAND_W-1:0] mcand,
  input  logic [DELTA_W-1:0] mplr,
  output logic               busy,
  output logic [PROD_W-1:0]  prod
);

  logic                 busy_r, busy_nxt;
  logic [MUL_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [MCAND_W:0]     acc_r, acc_nxt;
  logic [DELTA_W-1:0]   lo_r, lo_nxt;
  logic [MCAND_W-1:0]   mcand_r, mcand_nxt;
  logic [MCAND_W:0]     sum;

  // Add the multiplicand into the upper half when the current bit is set,
  // then shift the whole product one place right.
  always_comb begin
    sum       = acc_r + (lo_r[0] ? {1'b0, mcand_r} : '0);
    busy_nxt  = busy_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    lo_nxt    = lo_r;
    mcand_nxt = mcand_r;
    if (start) begin
      busy_nxt  = 1'b1;
      cnt_nxt   = MUL_CNT_W'(DELTA_W);
      acc_nxt   = '0;
      lo_nxt    = mplr;
      mcand_nxt = mcand;
    end else if (busy_r) begin
      acc_nxt  = {1'b0, sum[MCAND_W:1]};
      lo_nxt   = {sum[0], lo_r[DELTA_W-1:1]};
      cnt_nxt  = cnt_r - 1'b1;
      busy_nxt = (cnt_r != MUL_CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r   <= acc_nxt;
    lo_r    <= lo_nxt;
    mcand_r <= mcand_nxt;
  end

  assign busy = busy_r;
  assign prod = {acc_r[MCAND_W-1:0], lo_r};

endmodule

// ===== src/hce_div_serial.sv =====
`timescale 1ns / 1ps
// Restoring divider giving one quotient bit per cycle, saturating to 16 bits.
// Depends on hce_pkg for the numerator, denominator and quotient widths.
module hce_div_serial import hce_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [COP_W-1:0] quo
);

  logic                 busy_r, busy_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W-1:0]     rem_r, rem_nxt;
  logic [COP_W-1:0]     low_r, low_nxt;
  logic [DEN_W-1:0]     den_r, den_nxt;
  logic                 sat_r, sat_nxt;
  logic [DEN_W:0]       trial;
  logic                 fits;
  logic [DEN_W:0]       diff;

  // A quotient of 2^16 or more saturates; that is known from one compare at
  // start. Otherwise the upper numerator bits are already below the divisor.
  always_comb begin
    trial     = {rem_r, low_r[COP_W-1]};
    fits      = (trial >= {1'b0, den_r});
    diff      = trial - {1'b0, den_r};
    busy_nxt  = busy_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    low_nxt   = low_r;
    den_nxt   = den_r;
    sat_nxt   = sat_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(COP_W);
      den_nxt  = den;
      sat_nxt  = ({{(DEN_W + COP_W - NUM_W){1'b0}}, num} >= {den, {COP_W{1'b0}}});
      rem_nxt  = {{(DEN_W - NUM_W + COP_W){1'b0}}, num[NUM_W-1:COP_W]};
      low_nxt  = num[COP_W-1:0];
    end else if (busy_r) begin
      rem_nxt  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      low_nxt  = {low_r[COP_W-2:0], fits};
      cnt_nxt  = cnt_r - 1'b1;
      busy_nxt = (cnt_r != DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    low_r <= low_nxt;
    den_r <= den_nxt;
    sat_r <= sat_nxt;
  end

  assign busy = busy_r;
  assign quo  = sat_r ? {COP_W{1'b1}} : low_r;

endmodule

// ===== src/heating_cycle_efficiency_estimator.sv =====
`timescale 1ns / 1ps
// Top level of the heating cycle efficiency estimator: cycle tracking, sequencer
// and output register. Depends on hce_pkg, hce_mul_serial and hce_div_serial.
//
//   channel  | direction | handshake             | payload
//   in_      | input     | in_valid / in_stall   | one sample per beat
//   out_     | output    | out_valid / out_stall | one result per beat
//   cfg_     | input     | cfg_valid / cfg_ready | register index and data
//
// A sample that does not close a cycle has its result go straight to the output
// register. A closing sample stalls the input until its result beat is loaded:
// the sequencer forms the tank deltas, runs the two bit-serial multipliers over
// the delta bits with a handoff, the three bit-serial dividers over the quotient
// bits with a handoff, and then loads the output register. With no peak energy
// or no delta the multipliers and dividers are skipped.
// Reset is synchronous and clears all tracking and held state. While a result
// beat is stalled one further sample may be taken; its result waits inside.
module heating_cycle_efficiency_estimator import hce_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  // Sample channel.
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_running,
  input  logic signed [TEMP_W-1:0] in_top_temp,
  input  logic                     in_top_ok,
  input  logic signed [TEMP_W-1:0] in_middle_temp,
  input  logic                     in_middle_ok,
  input  logic [EN_W-1:0]          in_energy_used,
  input  logic [SEC_W-1:0]         in_cycle_seconds,
  // Result channel.
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [EV_W-1:0]          out_event_res,
  output logic                     out_estimate_ok,
  output logic [COP_W-1:0]         out_cop_low,
  output logic [COP_W-1:0]         out_cop_high,
  output logic [COP_W-1:0]         out_cop_mid,
  output logic signed [TEMP_W-1:0] out_report_start_middle,
  output logic signed [TEMP_W-1:0] out_report_end_middle,
  output logic signed [TEMP_W-1:0] out_report_start_bottom,
  // Configuration channel.
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CAP_W-1:0]         cfg_data
);

  // Sign-extended tank sum top + 2*middle + bottom.
  function automatic logic signed [S_W-1:0] tank_sum(
    input logic signed [TEMP_W-1:0] t,
    input logic signed [TEMP_W-1:0] m,
    input logic signed [TEMP_W-1:0] b
  );
    logic signed [S_W-1:0] te, me, be;
    te = S_W'(t);
    me = S_W'(m);
    be = S_W'(b);
    return te + (me <<< 1) + be;
  endfunction

  st_t state_r, state_nxt;

  // Configuration registers.
  logic [CAP_W-1:0] cap_r, cap_nxt;
  logic [SEC_W-1:0] win_r, win_nxt;

  // Cycle tracking.
  logic                     was_on_r, was_on_nxt;
  logic                     open_r, open_nxt;
  logic signed [TEMP_W-1:0] first_top_r, first_top_nxt;
  logic signed [TEMP_W-1:0] first_mid_r, first_mid_nxt;
  logic signed [TEMP_W-1:0] first_bot_r, first_bot_nxt;
  logic signed [TEMP_W-1:0] last_top_r, last_top_nxt;
  logic signed [TEMP_W-1:0] last_mid_r, last_mid_nxt;
  logic [EN_W-1:0]          peak_r, peak_nxt;

  // Held estimate.
  logic                     held_ok_r, held_ok_nxt;
  logic [COP_W-1:0]         held_low_r, held_low_nxt;
  logic [COP_W-1:0]         held_high_r, held_high_nxt;
  logic [COP_W-1:0]         held_mid_r, held_mid_nxt;
  logic signed [TEMP_W-1:0] held_smid_r, held_smid_nxt;
  logic signed [TEMP_W-1:0] held_emid_r, held_emid_nxt;
  logic signed [TEMP_W-1:0] held_sbot_r, held_sbot_nxt;
  ev_t                      ev_r, ev_nxt;

  // Output register.
  logic                     ov_r, ov_nxt;
  ev_t                      o_ev_r, o_ev_nxt;
  logic                     o_ok_r, o_ok_nxt;
  logic [COP_W-1:0]         o_low_r, o_low_nxt;
  logic [COP_W-1:0]         o_high_r, o_high_nxt;
  logic [COP_W-1:0]         o_mid_r, o_mid_nxt;
  logic signed [TEMP_W-1:0] o_smid_r, o_smid_nxt;
  logic signed [TEMP_W-1:0] o_emid_r, o_emid_nxt;
  logic signed [TEMP_W-1:0] o_sbot_r, o_sbot_nxt;

  // Sequencer controls.
  logic accept, samp_ok, closing, out_free, out_load;
  logic mul_start, div_start, div_done;
  ev_t  ev_now;

  // Delta datapath.
  logic signed [TEMP_W-1:0] bot_max;
  logic signed [DIFF_W-1:0] diff_min, diff_max, dmin_s;
  logic [DELTA_W-1:0]       dmin, dmax;
  logic                     go;
  logic [MCAND_W-1:0]       cap25;

  // Serial arithmetic lanes.
  logic              mul_lo_busy, mul_hi_busy, div_lo_busy, div_hi_busy, div_mid_busy;
  logic [PROD_W-1:0] prod_lo, prod_hi;
  logic [COP_W-1:0]  quo_lo, quo_hi, quo_mid;
  logic [NUM_W-1:0]  num_mid;

  assign accept   = in_valid && !in_stall;
  assign samp_ok  = in_top_ok && in_middle_ok;
  assign closing  = samp_ok && !in_running && open_r;
  assign out_free = !ov_r || !out_stall;
  assign div_done = !div_lo_busy && !div_hi_busy && !div_mid_busy;

  // Event caused by the sample at the input.
  always_comb begin
    ev_now = EV_NONE;
    if (samp_ok && in_running && (!was_on_r || !open_r)) begin
      ev_now = EV_START;
    end else if (closing) begin
      ev_now = EV_DONE;
    end
  end

  // Tank deltas in 1/64 K from the start and end temperatures.
  always_comb begin
    bot_max  = (first_bot_r > last_mid_r) ? first_bot_r : last_mid_r;
    diff_min = DIFF_W'(tank_sum(last_top_r, last_mid_r, first_bot_r))
             - DIFF_W'(tank_sum(first_top_r, first_mid_r, first_bot_r));
    diff_max = DIFF_W'(tank_sum(last_top_r, last_mid_r, bot_max))
             - DIFF_W'(tank_sum(first_top_r, first_mid_r, first_bot_r));
    dmin     = (diff_min > 0) ? diff_min[DELTA_W-1:0] : '0;
    dmin_s   = $signed({{(DIFF_W - DELTA_W){1'b0}}, dmin});
    dmax     = (diff_max > dmin_s) ? diff_max[DELTA_W-1:0] : dmin;
    go       = (peak_r != '0) && (dmax != '0);
    cap25    = (MCAND_W'(cap_r) << 4) + (MCAND_W'(cap_r) << 3) + MCAND_W'(cap_r);
    num_mid  = {1'b0, prod_lo} + {1'b0, prod_hi};
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (ev_now == EV_DONE) begin
            state_nxt = ST_PREP;
          end else if (!out_free) begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_PREP: state_nxt = go ? ST_MUL : ST_OUT;
      ST_MUL:  state_nxt = (mul_lo_busy || mul_hi_busy) ? ST_MUL : ST_DIV;
      ST_DIV:  state_nxt = div_done ? ST_OUT : ST_DIV;
      ST_OUT:  state_nxt = out_free ? ST_IDLE : ST_OUT;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall  = 1'b1;
    mul_start = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        out_load = in_valid && (ev_now != EV_DONE) && out_free;
      end
      ST_PREP: mul_start = go;
      ST_MUL:  div_start = !mul_lo_busy && !mul_hi_busy;
      ST_DIV:  out_load  = 1'b0;
      ST_OUT:  out_load  = out_free;
      default: in_stall  = 1'b1;
    endcase
  end

  assign cfg_ready = (state_r == ST_IDLE);

  // Configuration writes.
  always_comb begin
    cap_nxt = cap_r;
    win_nxt = win_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CAP:    cap_nxt = cfg_data;
        CFG_WINDOW: win_nxt = cfg_data;
        default:    cap_nxt = cap_r;
      endcase
    end
  end

  // Cycle tracking and held estimate.
  always_comb begin
    was_on_nxt    = was_on_r;
    open_nxt      = open_r;
    first_top_nxt = first_top_r;
    first_mid_nxt = first_mid_r;
    first_bot_nxt = first_bot_r;
    last_top_nxt  = last_top_r;
    last_mid_nxt  = last_mid_r;
    peak_nxt      = peak_r;
    held_ok_nxt   = held_ok_r;
    held_low_nxt  = held_low_r;
    held_high_nxt = held_high_r;
    held_mid_nxt  = held_mid_r;
    held_smid_nxt = held_smid_r;
    held_emid_nxt = held_emid_r;
    held_sbot_nxt = held_sbot_r;
    ev_nxt        = ev_r;
    if (state_r == ST_IDLE && accept) begin
      ev_nxt = ev_now;
      if (samp_ok && in_running) begin
        was_on_nxt   = 1'b1;
        last_top_nxt = in_top_temp;
        last_mid_nxt = in_middle_temp;
        if (ev_now == EV_START) begin
          open_nxt      = 1'b1;
          first_top_nxt = in_top_temp;
          first_mid_nxt = in_middle_temp;
          first_bot_nxt = in_top_temp;
          peak_nxt      = in_energy_used;
          held_ok_nxt   = 1'b0;
          held_low_nxt  = '0;
          held_high_nxt = '0;
          held_mid_nxt  = '0;
          held_smid_nxt = '0;
          held_emid_nxt = '0;
          held_sbot_nxt = '0;
        end else begin
          if (in_energy_used > peak_r) begin
            peak_nxt = in_energy_used;
          end
          if (in_cycle_seconds <= win_r && in_top_temp < first_bot_r) begin
            first_bot_nxt = in_top_temp;
          end
        end
      end else if (samp_ok) begin
        // A stopped sample; it closes the cycle if one is open.
        was_on_nxt = 1'b0;
        if (open_r) begin
          open_nxt     = 1'b0;
          last_top_nxt = (in_top_temp > last_top_r) ? in_top_temp : last_top_r;
          last_mid_nxt = (in_middle_temp > last_mid_r) ? in_middle_temp : last_mid_r;
          if (in_energy_used > peak_r) begin
            peak_nxt = in_energy_used;
          end
        end
      end
    end else if (state_r == ST_PREP) begin
      held_ok_nxt   = 1'b0;
      held_low_nxt  = '0;
      held_high_nxt = '0;
      held_mid_nxt  = '0;
      held_smid_nxt = first_mid_r;
      held_emid_nxt = last_mid_r;
      held_sbot_nxt = first_bot_r;
    end else if (state_r == ST_DIV && div_done) begin
      held_ok_nxt   = 1'b1;
      held_low_nxt  = quo_lo;
      held_high_nxt = quo_hi;
      held_mid_nxt  = quo_mid;
    end
  end

  // Output register: a start beat reports the cleared estimate.
  always_comb begin
    ov_nxt     = out_stall ? ov_r : 1'b0;
    o_ev_nxt   = o_ev_r;
    o_ok_nxt   = o_ok_r;
    o_low_nxt  = o_low_r;
    o_high_nxt = o_high_r;
    o_mid_nxt  = o_mid_r;
    o_smid_nxt = o_smid_r;
    o_emid_nxt = o_emid_r;
    o_sbot_nxt = o_sbot_r;
    if (out_load) begin
      ov_nxt     = 1'b1;
      o_ev_nxt   = (state_r == ST_IDLE) ? ev_now : ev_r;
      o_ok_nxt   = held_ok_r;
      o_low_nxt  = held_low_r;
      o_high_nxt = held_high_r;
      o_mid_nxt  = held_mid_r;
      o_smid_nxt = held_smid_r;
      o_emid_nxt = held_emid_r;
      o_sbot_nxt = held_sbot_r;
      if (state_r == ST_IDLE && ev_now == EV_START) begin
        o_ok_nxt   = 1'b0;
        o_low_nxt  = '0;
        o_high_nxt = '0;
        o_mid_nxt  = '0;
        o_smid_nxt = '0;
        o_emid_nxt = '0;
        o_sbot_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= CAP_RESET;
      win_r       <= WINDOW_RESET;
      was_on_r    <= 1'b0;
      open_r      <= 1'b0;
      first_top_r <= '0;
      first_mid_r <= '0;
      first_bot_r <= '0;
      last_top_r  <= '0;
      last_mid_r  <= '0;
      peak_r      <= '0;
      held_ok_r   <= 1'b0;
      held_low_r  <= '0;
      held_high_r <= '0;
      held_mid_r  <= '0;
      held_smid_r <= '0;
      held_emid_r <= '0;
      held_sbot_r <= '0;
      ev_r        <= EV_NONE;
      ov_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cap_r       <= cap_nxt;
      win_r       <= win_nxt;
      was_on_r    <= was_on_nxt;
      open_r      <= open_nxt;
      first_top_r <= first_top_nxt;
      first_mid_r <= first_mid_nxt;
      first_bot_r <= first_bot_nxt;
      last_top_r  <= last_top_nxt;
      last_mid_r  <= last_mid_nxt;
      peak_r      <= peak_nxt;
      held_ok_r   <= held_ok_nxt;
      held_low_r  <= held_low_nxt;
      held_high_r <= held_high_nxt;
      held_mid_r  <= held_mid_nxt;
      held_smid_r <= held_smid_nxt;
      held_emid_r <= held_emid_nxt;
      held_sbot_r <= held_sbot_nxt;
      ev_r        <= ev_nxt;
      ov_r        <= ov_nxt;
    end
    o_ev_r   <= o_ev_nxt;
    o_ok_r   <= o_ok_nxt;
    o_low_r  <= o_low_nxt;
    o_high_r <= o_high_nxt;
    o_mid_r  <= o_mid_nxt;
    o_smid_r <= o_smid_nxt;
    o_emid_r <= o_emid_nxt;
    o_sbot_r <= o_sbot_nxt;
  end

  // Heat products: capacity times 25 times each delta.
  hce_mul_serial u_mul_lo (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .mcand (cap25),
    .mplr  (dmin),
    .busy  (mul_lo_busy),
    .prod  (prod_lo)
  );

  hce_mul_serial u_mul_hi (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .mcand (cap25),
    .mplr  (dmax),
    .busy  (mul_hi_busy),
    .prod  (prod_hi)
  );

  // COP bounds and midpoint, divided by the peak energy.
  hce_div_serial u_div_lo (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   ({1'b0, prod_lo}),
    .den   ({1'b0, peak_r}),
    .busy  (div_lo_busy),
    .quo   (quo_lo)
  );

  hce_div_serial u_div_hi (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   ({1'b0, prod_hi}),
    .den   ({1'b0, peak_r}),
    .busy  (div_hi_busy),
    .quo   (quo_hi)
  );

  hce_div_serial u_div_mid (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_mid),
    .den   ({peak_r, 1'b0}),
    .busy  (div_mid_busy),
    .quo   (quo_mid)
  );

  assign out_valid               = ov_r;
  assign out_event_res           = o_ev_r;
  assign out_estimate_ok         = o_ok_r;
  assign out_cop_low             = o_low_r;
  assign out_cop_high            = o_high_r;
  assign out_cop_mid             = o_mid_r;
  assign out_report_start_middle = o_smid_r;
  assign out_report_end_middle   = o_emid_r;
  assign out_report_start_bottom = o_sbot_r;

endmodule

// ===== src/hce_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the heating cycle efficiency estimator, bound to the top.
// Depends on hce_pkg for widths and event codes.
module hce_checker import hce_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic [EV_W-1:0]          out_event_res,
  input logic                     out_estimate_ok,
  input logic [COP_W-1:0]         out_cop_low,
  input logic [COP_W-1:0]         out_cop_high,
  input logic [COP_W-1:0]         out_cop_mid,
  input logic signed [TEMP_W-1:0] out_report_start_middle,
  input logic signed [TEMP_W-1:0] out_report_end_middle,
  input logic signed [TEMP_W-1:0] out_report_start_bottom
);

  // No result beat is offered right after reset.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat offered after reset");

  // A stalled result beat stays and keeps its estimate.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_cop_mid) &&
      $stable(out_event_res) && $stable(out_estimate_ok))
    else $error("stalled result beat changed");

  // Without a valid estimate all COP values read zero.
  a_no_est_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_estimate_ok |->
      out_cop_low == '0 && out_cop_high == '0 && out_cop_mid == '0)
    else $error("COP values without a valid estimate");

  // The midpoint lies between the bounds.
  a_mid_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_estimate_ok |->
      out_cop_low <= out_cop_mid && out_cop_mid <= out_cop_high)
    else $error("COP midpoint outside its bounds");

  // A cycle start reports a cleared estimate.
  a_start_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res == EV_START |->
      !out_estimate_ok && out_report_start_middle == '0 &&
      out_report_end_middle == '0 && out_report_start_bottom == '0)
    else $error("cycle start with a held estimate");

endmodule

bind heating_cycle_efficiency_estimator hce_checker u_hce_checker (
  .clk                     (clk),
  .rst_n                   (rst_n),
  .out_valid               (out_valid),
  .out_stall               (out_stall),
  .out_event_res           (out_event_res),
  .out_estimate_ok         (out_estimate_ok),
  .out_cop_low             (out_cop_low),
  .out_cop_high            (out_cop_high),
  .out_cop_mid             (out_cop_mid),
  .out_report_start_middle (out_report_start_middle),
  .out_report_end_middle   (out_report_end_middle),
  .out_report_start_bottom (out_report_start_bottom)
);

// ===== dv/hce_cop_monitor.sv =====
`timescale 1ns / 1ps
// Result monitor for the heating cycle efficiency estimator. It tracks accepted sample
// beats and register writes, predicts every result beat and compares it field by field.
// Depends on hce_pkg.
module hce_cop_monitor import hce_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic                     in_running,
  input  logic signed [TEMP_W-1:0] in_top_temp,
  input  logic                     in_top_ok,
  input  logic signed [TEMP_W-1:0] in_middle_temp,
  input  logic                     in_middle_ok,
  input  logic [EN_W-1:0]          in_energy_used,
  input  logic [SEC_W-1:0]         in_cycle_seconds,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic [EV_W-1:0]          out_event_res,
  input  logic                     out_estimate_ok,
  input  logic [COP_W-1:0]         out_cop_low,
  input  logic [COP_W-1:0]         out_cop_high,
  input  logic [COP_W-1:0]         out_cop_mid,
  input  logic signed [TEMP_W-1:0] out_report_start_middle,
  input  logic signed [TEMP_W-1:0] out_report_end_middle,
  input  logic signed [TEMP_W-1:0] out_report_start_bottom,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CAP_W-1:0]         cfg_data,
  output int                       fail_count,
  output int                       estimates_owed,
  output int                       cycles_opened,
  output int                       cycles_closed,
  output int                       cop_estimates,
  output int                       samples_ignored
);

  localparam int MAX_REPORTED = 30;
  localparam longint unsigned COP_CEIL = 65535;

  // One expected result beat.
  typedef struct {
    ev_t               ev;
    logic              ok;
    logic [COP_W-1:0]  cop_lo;
    logic [COP_W-1:0]  cop_hi;
    logic [COP_W-1:0]  cop_md;
    logic [TEMP_W-1:0] start_mid;
    logic [TEMP_W-1:0] end_mid;
    logic [TEMP_W-1:0] start_bot;
  } estimate_t;

  estimate_t estimate_q[$];
  int        result_idx;

  // Register copies.
  logic [CAP_W-1:0] heat_cap;
  logic [SEC_W-1:0] window_s;

  // Cycle tracking and the held estimate.
  logic             was_running;
  logic             cycle_live;
  int               start_top;
  int               start_mid;
  int               bottom_min;
  int               end_top;
  int               end_mid;
  logic [EN_W-1:0]  energy_peak;
  logic             held_valid;
  logic [COP_W-1:0] held_lo;
  logic [COP_W-1:0] held_hi;
  logic [COP_W-1:0] held_md;
  int               held_start_mid;
  int               held_end_mid;
  int               held_start_bot;

  function automatic int larger(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  // Truncating division that clips at the top of the 8.8 range.
  function automatic logic [COP_W-1:0] cop_quotient(input longint unsigned num,
                                                    input longint unsigned den);
    longint unsigned q;
    q = num / den;
    return (q > COP_CEIL) ? '1 : q[COP_W-1:0];
  endfunction

  function automatic void drop_held();
    held_valid     = 1'b0;
    held_lo        = '0;
    held_hi        = '0;
    held_md        = '0;
    held_start_mid = 0;
    held_end_mid   = 0;
    held_start_bot = 0;
  endfunction

  task automatic log_mismatch(input string what);
    if (fail_count < MAX_REPORTED)
      $display("%0t ns: mismatch: %s", $time, what);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      log_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                             result_idx, name, got, want));
  endtask

  // Advance the cycle tracker by one accepted sample and return the result it gives.
  task automatic predict_estimate(output estimate_t e);
    int top;
    int mid;
    int s_start;
    int s_min;
    int s_max;
    int d_lo;
    int d_hi;
    longint unsigned scale;
    ev_t ev;
    top = in_top_temp;
    mid = in_middle_temp;
    ev  = EV_NONE;
    if (!(in_top_ok && in_middle_ok)) begin
      samples_ignored++;
    end else if (in_running) begin
      if (!was_running || !cycle_live) begin
        // A new cycle latches the start temperatures and clears the held estimate.
        cycle_live  = 1'b1;
        start_top   = top;
        start_mid   = mid;
        bottom_min  = top;
        end_top     = top;
        end_mid     = mid;
        energy_peak = in_energy_used;
        drop_held();
        ev = EV_START;
        cycles_opened++;
      end else begin
        end_top = top;
        end_mid = mid;
        if (in_energy_used > energy_peak)
          energy_peak = in_energy_used;
        if (in_cycle_seconds <= window_s && top < bottom_min)
          bottom_min = top;
      end
      was_running = 1'b1;
    end else begin
      was_running = 1'b0;
      if (cycle_live) begin
        // Closing sample: tank sums in 1/64 K, then the COP bounds from the deltas.
        end_top = larger(end_top, top);
        end_mid = larger(end_mid, mid);
        if (in_energy_used > energy_peak)
          energy_peak = in_energy_used;
        s_start = start_top + 2 * start_mid + bottom_min;
        s_min   = end_top + 2 * end_mid + bottom_min;
        s_max   = end_top + 2 * end_mid + larger(bottom_min, end_mid);
        d_lo    = larger(0, s_min - s_start);
        d_hi    = larger(d_lo, s_max - s_start);
        drop_held();
        held_start_mid = start_mid;
        held_end_mid   = end_mid;
        held_start_bot = bottom_min;
        if (energy_peak != 0 && d_hi > 0) begin
          scale      = 64'(heat_cap) * 25;
          held_lo    = cop_quotient(scale * 64'(d_lo), 64'(energy_peak));
          held_hi    = cop_quotient(scale * 64'(d_hi), 64'(energy_peak));
          held_md    = cop_quotient(scale * (64'(d_lo) + 64'(d_hi)), 2 * 64'(energy_peak));
          held_valid = 1'b1;
          cop_estimates++;
        end
        cycle_live = 1'b0;
        ev = EV_DONE;
        cycles_closed++;
      end
    end
    e.ev        = ev;
    e.ok        = held_valid;
    e.cop_lo    = held_lo;
    e.cop_hi    = held_hi;
    e.cop_md    = held_md;
    e.start_mid = held_start_mid[TEMP_W-1:0];
    e.end_mid   = held_end_mid[TEMP_W-1:0];
    e.start_bot = held_start_bot[TEMP_W-1:0];
  endtask

  // Watch all three channels at every rising edge.
  always @(posedge clk) begin
    estimate_t want;
    estimate_t next;
    if (!rst_n) begin
      heat_cap    = CAP_RESET;
      window_s    = WINDOW_RESET;
      was_running = 1'b0;
      cycle_live  = 1'b0;
      start_top   = 0;
      start_mid   = 0;
      bottom_min  = 0;
      end_top     = 0;
      end_mid     = 0;
      energy_peak = '0;
      drop_held();
      estimate_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CAP:    heat_cap = cfg_data;
          CFG_WINDOW: window_s = cfg_data;
          default:    ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (estimate_q.size() == 0) begin
          log_mismatch($sformatf("result %0d arrived with none expected", result_idx));
        end else begin
          want = estimate_q.pop_front();
          check_field("event_res", 32'(out_event_res), 32'(want.ev));
          check_field("estimate_ok", 32'(out_estimate_ok), 32'(want.ok));
          check_field("cop_low", 32'(out_cop_low), 32'(want.cop_lo));
          check_field("cop_high", 32'(out_cop_high), 32'(want.cop_hi));
          check_field("cop_mid", 32'(out_cop_mid), 32'(want.cop_md));
          check_field("report_start_middle", 32'(out_report_start_middle[TEMP_W-1:0]),
                      32'(want.start_mid));
          check_field("report_end_middle", 32'(out_report_end_middle[TEMP_W-1:0]),
                      32'(want.end_mid));
          check_field("report_start_bottom", 32'(out_report_start_bottom[TEMP_W-1:0]),
                      32'(want.start_bot));
        end
        result_idx++;
      end
      if (in_valid && !in_stall) begin
        predict_estimate(next);
        estimate_q.push_back(next);
      end
    end
    estimates_owed = estimate_q.size();
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Top of the estimator testbench: clock, reset, sample and register stimulus,
// result back-pressure, watchdog and verdict. Depends on hce_pkg, the block and
// hce_cop_monitor.
module testbench;
  import hce_pkg::*;

  localparam int SETTLE_CYCLES  = 40;
  localparam int TAIL_CYCLES    = 60;
  localparam int IDLE_LIMIT     = 3000;
  localparam int SQUEEZE_CYCLES = 300;
  localparam int unsigned EN_MAX  = 32'hFFFFFF;
  localparam int unsigned SEC_MAX = 32'hFFFF;

  // Register indexes past the last register; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  typedef enum {FLOW_FREE, FLOW_CHOPPY, FLOW_HELD} flow_t;

  typedef struct {
    logic        run;
    int          top;
    logic        top_ok;
    int          mid;
    logic        mid_ok;
    int unsigned energy;
    int unsigned secs;
  } sample_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     in_running = 1'b0;
  logic signed [TEMP_W-1:0] in_top_temp = '0;
  logic                     in_top_ok = 1'b0;
  logic signed [TEMP_W-1:0] in_middle_temp = '0;
  logic                     in_middle_ok = 1'b0;
  logic [EN_W-1:0]          in_energy_used = '0;
  logic [SEC_W-1:0]         in_cycle_seconds = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [EV_W-1:0]          out_event_res;
  logic                     out_estimate_ok;
  logic [COP_W-1:0]         out_cop_low;
  logic [COP_W-1:0]         out_cop_high;
  logic [COP_W-1:0]         out_cop_mid;
  logic signed [TEMP_W-1:0] out_report_start_middle;
  logic signed [TEMP_W-1:0] out_report_end_middle;
  logic signed [TEMP_W-1:0] out_report_start_bottom;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CAP_W-1:0]         cfg_data = '0;

  int fail_count;
  int estimates_owed;
  int cycles_opened;
  int cycles_closed;
  int cop_estimates;
  int samples_ignored;

  int items_sent;
  int burst_left;
  int idle_cycles;
  bit squeeze_req;

  heating_cycle_efficiency_estimator dut (.*);

  hce_cop_monitor cop_monitor (.*);

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog: the run is stuck if no beat moves on any channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog: no beat for %0d cycles, %0d results outstanding",
               idle_cycles, estimates_owed);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result back-pressure: free-flowing, choppy and held stretches, plus one long
  // hold on request so the block fills up and stalls its input.
  initial begin : result_backpressure
    flow_t flow;
    int    span;
    int    pick;
    bit    squeezed;
    squeezed = 1'b0;
    forever begin
      pick = $urandom_range(0, 99);
      if (squeeze_req && !squeezed) begin
        squeezed = 1'b1;
        flow     = FLOW_HELD;
        span     = SQUEEZE_CYCLES;
      end else if (pick < 30) begin
        flow = FLOW_FREE;
        span = $urandom_range(10, 80);
      end else if (pick < 92) begin
        flow = FLOW_CHOPPY;
        span = $urandom_range(10, 60);
      end else begin
        flow = FLOW_HELD;
        span = $urandom_range(20, 90);
      end
      repeat (span) begin
        @(posedge clk);
        case (flow)
          FLOW_FREE:   out_stall <= 1'b0;
          FLOW_CHOPPY: out_stall <= ($urandom_range(0, 3) == 0);
          default:     out_stall <= 1'b1;
        endcase
      end
    end
  end

  function automatic int clamp_temp(input int t);
    return (t > 2047) ? 2047 : (t < -2048) ? -2048 : t;
  endfunction

  function automatic int rand_temp();
    return int'($urandom_range(0, 4095)) - 2048;
  endfunction

  function automatic int unsigned sat_add(input int unsigned base, input int unsigned inc,
                                          input int unsigned ceil);
    return (base + inc > ceil) ? ceil : base + inc;
  endfunction

  function automatic sample_t make_sample(input logic run, input int top, input logic top_ok,
                                          input int mid, input logic mid_ok,
                                          input int unsigned energy, input int unsigned secs);
    sample_t s;
    s.run    = run;
    s.top    = top;
    s.top_ok = top_ok;
    s.mid    = mid;
    s.mid_ok = mid_ok;
    s.energy = energy;
    s.secs   = secs;
    return s;
  endfunction

  // Anything the fields allow, valid flags included.
  function automatic sample_t random_sample();
    return make_sample(1'($urandom_range(0, 1)), rand_temp(), 1'($urandom_range(0, 1)),
                       rand_temp(), 1'($urandom_range(0, 1)), $urandom_range(0, EN_MAX),
                       $urandom_range(0, SEC_MAX));
  endfunction

  // Offer one sample beat after a random gap and hold it until it is taken.
  task automatic send_sample(input sample_t s);
    int pick;
    int gap;
    gap = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 8)
        burst_left = $urandom_range(10, 40);
      else if (pick >= 50 && pick < 93)
        gap = $urandom_range(1, 4);
      else if (pick >= 93)
        gap = $urandom_range(10, 60);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_running       <= s.run;
    in_top_temp      <= s.top[TEMP_W-1:0];
    in_top_ok        <= s.top_ok;
    in_middle_temp   <= s.mid[TEMP_W-1:0];
    in_middle_ok     <= s.mid_ok;
    in_energy_used   <= s.energy[EN_W-1:0];
    in_cycle_seconds <= s.secs[SEC_W-1:0];
    do @(posedge clk); while (in_stall);
    if (s.top_ok && s.mid_ok)
      items_sent++;
  endtask

  // One heating cycle: a start, some running samples with drifting temperatures and
  // growing energy, then a stop. Stray samples are mixed in now and then.
  task automatic heat_cycle();
    sample_t s;
    int      n_on;
    n_on = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 6);
    s.run    = 1'b1;
    s.top_ok = 1'b1;
    s.mid_ok = 1'b1;
    if ($urandom_range(0, 9) == 0) begin
      s.top = rand_temp();
      s.mid = rand_temp();
    end else begin
      s.top = $urandom_range(160, 960);
      s.mid = clamp_temp(s.top - int'($urandom_range(0, 160)));
    end
    s.energy = ($urandom_range(0, 9) == 0) ? $urandom_range(0, EN_MAX) : $urandom_range(0, 500);
    s.secs   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
    send_sample(s);
    for (int k = 0; k <= n_on; k++) begin
      if ($urandom_range(0, 9) == 0)
        send_sample(random_sample());
      s.run = (k < n_on);
      if ($urandom_range(0, 11) == 0) begin
        s.top = rand_temp();
        s.mid = rand_temp();
      end else begin
        s.top = clamp_temp(s.top + int'($urandom_range(0, 48)) - 8);
        s.mid = clamp_temp(s.mid + int'($urandom_range(0, 48)) - 8);
      end
      s.energy = ($urandom_range(0, 19) == 0) ? $urandom_range(0, EN_MAX) :
                 sat_add(s.energy, $urandom_range(0, 30000), EN_MAX);
      s.secs   = ($urandom_range(0, 19) == 0) ? $urandom_range(0, SEC_MAX) :
                 sat_add(s.secs, $urandom_range(5, 150), SEC_MAX);
      send_sample(s);
    end
  endtask

  task automatic random_phase(input int count);
    int goal;
    goal = items_sent + count;
    while (items_sent < goal) begin
      if ($urandom_range(0, 4) == 0)
        send_sample(random_sample());
      else
        heat_cycle();
    end
  endtask

  // Drain the block, then write a spare index and both registers.
  task automatic apply_settings(input logic [CAP_W-1:0] cap, input logic [SEC_W-1:0] win);
    logic [CFG_IDX_W-1:0] idx [3];
    logic [CAP_W-1:0]     val [3];
    in_valid <= 1'b0;
    idx[0] = ($urandom_range(0, 1) == 0) ? CFG_SPARE_LO : CFG_SPARE_HI;
    val[0] = 16'($urandom);
    idx[1] = CFG_CAP;
    val[1] = cap;
    idx[2] = CFG_WINDOW;
    val[2] = win;
    do @(negedge clk); while (estimates_owed != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    foreach (idx[i]) begin
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Stop with no open cycle, then samples with a bad temperature reading.
    send_sample(make_sample(1'b0, 400, 1'b1, 380, 1'b1, 0, 0));
    send_sample(make_sample(1'b1, 400, 1'b0, 380, 1'b1, 100, 5));
    send_sample(make_sample(1'b1, 400, 1'b1, 380, 1'b0, 100, 5));
    send_sample(make_sample(1'b1, 400, 1'b0, 380, 1'b0, 100, 5));
    // Cycle across the full temperature and energy range; the window edge is inclusive.
    send_sample(make_sample(1'b1, -2048, 1'b1, -2048, 1'b1, 0, 0));
    send_sample(make_sample(1'b1, 2047, 1'b1, 2047, 1'b1, EN_MAX, 300));
    send_sample(make_sample(1'b1, -100, 1'b1, 2047, 1'b1, 1000, 301));
    send_sample(make_sample(1'b0, 2047, 1'b0, 0, 1'b1, 5, 5));
    send_sample(make_sample(1'b0, 2047, 1'b1, 2047, 1'b1, 32'h800000, SEC_MAX));
    send_sample(make_sample(1'b0, 0, 1'b1, 0, 1'b1, 0, 0));
    // Cycle with no energy used.
    send_sample(make_sample(1'b1, 0, 1'b1, 0, 1'b1, 0, 0));
    send_sample(make_sample(1'b1, 800, 1'b1, 800, 1'b1, 0, 10));
    send_sample(make_sample(1'b0, 800, 1'b1, 800, 1'b1, 0, 20));
    // Tiny energy against a large temperature rise saturates the COP.
    send_sample(make_sample(1'b1, 100, 1'b1, 100, 1'b1, 1, 0));
    send_sample(make_sample(1'b1, 1600, 1'b1, 1600, 1'b1, 1, 400));
    send_sample(make_sample(1'b0, 1600, 1'b1, 1600, 1'b1, 1, 500));
    // Tank cools down over the cycle: no upper delta.
    send_sample(make_sample(1'b1, 500, 1'b1, 500, 1'b1, 50, 0));
    send_sample(make_sample(1'b0, -300, 1'b1, -300, 1'b1, 900, 10));
    // Ordinary cycle: bottom minimum inside the window, energy dipping below its peak.
    send_sample(make_sample(1'b1, 640, 1'b1, 600, 1'b1, 200, 0));
    send_sample(make_sample(1'b1, 560, 1'b1, 620, 1'b1, 5000, 60));
    send_sample(make_sample(1'b1, 900, 1'b1, 880, 1'b1, 3000, 200));
    send_sample(make_sample(1'b0, 950, 1'b1, 900, 1'b1, 4000, 260));

    random_phase(150);
    apply_settings('0, '0);
    random_phase(120);
    apply_settings('1, '1);
    squeeze_req = 1'b1;
    random_phase(150);
    apply_settings(16'($urandom), 16'($urandom));
    random_phase(150);
    apply_settings(16'($urandom_range(1, 255)), 16'($urandom_range(0, 600)));
    random_phase(150);
    apply_settings(CAP_RESET, WINDOW_RESET);
    random_phase(180);

    in_valid <= 1'b0;
    do @(negedge clk); while (estimates_owed != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d valid samples and %0d ignored ones over six register settings;",
             items_sent, samples_ignored);
    $display("%0d cycles opened, %0d closed, %0d of them with a COP estimate.",
             cycles_opened, cycles_closed, cop_estimates);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
